/* sv/rtta_pkg.sv */
// shared types and constants for the real-time timer with alarm
package rtta_pkg;

    localparam int DATA_W = 32;

    // request opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // register indexes
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_ALARM  = 2'd1;
    localparam logic [1:0] REG_VALUE  = 2'd2;
    localparam logic [1:0] REG_STATUS = 2'd3;

    // mode register bit positions
    localparam int MODE_ALM_EN = 16;
    localparam int MODE_INC_EN = 17;
    localparam int MODE_RST    = 18;

    // status register bit positions
    localparam int STAT_ALARM = 0;
    localparam int STAT_INCR  = 1;

    localparam logic [15:0] PRESCALE_RESET = 16'h8000;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [1:0]        reg_index;
        logic [DATA_W-1:0] write_data;
    } t_request;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq;
    } t_result;

endpackage

/* sv/real_time_timer_with_alarm_unit.sv */
// top level: request register, timer core and result register
//
//  channel   signals                                    direction
//  request   i_valid o_ready i_opcode i_reg_index       in
//            i_write_data
//  result    o_valid i_ready o_read_data o_irq          out
//
// each request is held in the request register and is executed in the
// cycle it moves to the result register; a new request is taken every
// cycle while the result is not stalled. all timer state updates in that
// single execute step. reset is synchronous; a stalled result holds the result
// register, which holds the request register, so nothing is lost.
module real_time_timer_with_alarm_unit #(
    parameter int PRESCALE_BITS = 16,
    parameter int COUNT_BITS    = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [1:0]  i_reg_index,
    input  logic [31:0] i_write_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_read_data,
    output logic        o_irq
);
    import rtta_pkg::*;

    logic      r_req_vld;
    t_request  r_req;
    logic      r_res_vld;
    t_result   r_res;
    t_result   core_res;
    logic      advance;

    assign advance = r_req_vld && (!r_res_vld || i_ready);
    assign o_ready = !r_req_vld || advance;

    rtta_core #(
        .PRESCALE_BITS (PRESCALE_BITS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_exec  (advance),
        .i_req   (r_req),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            if (o_ready) begin
                r_req_vld <= i_valid;
            end
            if (advance) begin
                r_res_vld <= 1'b1;
            end else if (i_ready) begin
                r_res_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req.opcode     <= i_opcode;
            r_req.reg_index  <= i_reg_index;
            r_req.write_data <= i_write_data;
        end
        if (advance) begin
            r_res <= core_res;
        end
    end

    assign o_valid     = r_res_vld;
    assign o_read_data = r_res.read_data;
    assign o_irq       = r_res.irq;

endmodule

/* sv/rtta_core.sv */
// timer state registers and the combinational next-state update for one request
module rtta_core #(
    parameter int PRESCALE_BITS = 16,
    parameter int COUNT_BITS    = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_exec,
    input  rtta_pkg::t_request i_req,
    output rtta_pkg::t_result  o_res
);
    import rtta_pkg::*;

    logic [PRESCALE_BITS-1:0] r_pvalue, n_pvalue;
    logic [PRESCALE_BITS-1:0] r_pcount, n_pcount;
    logic [COUNT_BITS-1:0]    r_time, n_time;
    logic [COUNT_BITS-1:0]    r_alarm, n_alarm;
    logic                     r_alm_en, n_alm_en;
    logic                     r_inc_en, n_inc_en;
    logic                     r_alm_flag, n_alm_flag;
    logic                     r_inc_flag, n_inc_flag;

    logic [PRESCALE_BITS:0]   cnt_inc;
    logic [PRESCALE_BITS:0]   period;
    logic [COUNT_BITS-1:0]    time_inc;
    logic [DATA_W-1:0]        rdata;

    assign cnt_inc  = {1'b0, r_pcount} + (PRESCALE_BITS+1)'(1);
    // zero prescaler means a full 2^PRESCALE_BITS period
    assign period   = (r_pvalue == '0) ? {1'b1, {PRESCALE_BITS{1'b0}}} : {1'b0, r_pvalue};
    assign time_inc = r_time + COUNT_BITS'(1);

    always_comb begin
        n_pvalue   = r_pvalue;
        n_pcount   = r_pcount;
        n_time     = r_time;
        n_alarm    = r_alarm;
        n_alm_en   = r_alm_en;
        n_inc_en   = r_inc_en;
        n_alm_flag = r_alm_flag;
        n_inc_flag = r_inc_flag;
        rdata      = '0;
        if (i_exec) begin
            unique case (i_req.opcode)
                OP_TICK: begin
                    if (cnt_inc >= period) begin
                        n_pcount   = '0;
                        n_time     = time_inc;
                        n_inc_flag = 1'b1;
                        if (time_inc == r_alarm) begin
                            n_alm_flag = 1'b1;
                        end
                    end else begin
                        n_pcount = cnt_inc[PRESCALE_BITS-1:0];
                    end
                end
                OP_READ: begin
                    unique case (i_req.reg_index)
                        REG_MODE: begin
                            rdata              = DATA_W'(r_pvalue);
                            rdata[MODE_ALM_EN] = r_alm_en;
                            rdata[MODE_INC_EN] = r_inc_en;
                        end
                        REG_ALARM: rdata = DATA_W'(r_alarm);
                        REG_VALUE: rdata = DATA_W'(r_time);
                        REG_STATUS: begin
                            rdata[STAT_ALARM] = r_alm_flag;
                            rdata[STAT_INCR]  = r_inc_flag;
                            n_alm_flag        = 1'b0;
                            n_inc_flag        = 1'b0;
                        end
                        default: rdata = '0;
                    endcase
                end
                OP_WRITE: begin
                    if (i_req.reg_index == REG_MODE) begin
                        n_pvalue = i_req.write_data[PRESCALE_BITS-1:0];
                        n_alm_en = i_req.write_data[MODE_ALM_EN];
                        n_inc_en = i_req.write_data[MODE_INC_EN];
                        if (i_req.write_data[MODE_RST]) begin
                            n_pcount = '0;
                            n_time   = '0;
                        end
                    end else if (i_req.reg_index == REG_ALARM) begin
                        n_alarm = i_req.write_data[COUNT_BITS-1:0];
                    end
                end
                default: rdata = '0;
            endcase
        end
    end

    assign o_res.read_data = rdata;
    assign o_res.irq       = (n_alm_flag & n_alm_en) | (n_inc_flag & n_inc_en);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalue   <= PRESCALE_RESET[PRESCALE_BITS-1:0];
            r_pcount   <= '0;
            r_time     <= '0;
            r_alarm    <= '1;
            r_alm_en   <= 1'b0;
            r_inc_en   <= 1'b0;
            r_alm_flag <= 1'b0;
            r_inc_flag <= 1'b0;
        end else begin
            r_pvalue   <= n_pvalue;
            r_pcount   <= n_pcount;
            r_time     <= n_time;
            r_alarm    <= n_alarm;
            r_alm_en   <= n_alm_en;
            r_inc_en   <= n_inc_en;
            r_alm_flag <= n_alm_flag;
            r_inc_flag <= n_inc_flag;
        end
    end

endmodule

/* sim/real_time_timer_with_alarm_unit_test.sv */
// testbench for the real-time timer with alarm: directed table, zero prescaler burst, random requests
`timescale 1ns / 100ps

module real_time_timer_with_alarm_unit_test;
    import rtta_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 500;
    localparam int DIR_N = 25;
    localparam int DRAIN_CYCLES = 8;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_opcode = OP_TICK;
    logic [1:0]  i_reg_index = REG_MODE;
    logic [31:0] i_write_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_read_data;
    logic        o_irq;

    real_time_timer_with_alarm_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_reg_index  (i_reg_index),
        .i_write_data (i_write_data),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_read_data  (o_read_data),
        .o_irq        (o_irq)
    );

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  idx;
        logic [31:0] data;
        logic        known;
        logic [31:0] rd;
        logic        irq;
    } t_row;

    // known rows carry a result that holds right after reset or for an unused opcode
    t_row dir_rows [DIR_N] = '{
        '{OP_READ,  REG_MODE,   32'h0000_0000, 1'b1, 32'h0000_8000, 1'b0},
        '{OP_READ,  REG_ALARM,  32'h0000_0000, 1'b1, 32'hffff_ffff, 1'b0},
        '{OP_READ,  REG_VALUE,  32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
        '{OP_READ,  REG_STATUS, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
        '{OP_NONE,  REG_STATUS, 32'hffff_ffff, 1'b1, 32'h0000_0000, 1'b0},
        '{OP_WRITE, REG_MODE,   32'h0007_0001, 1'b0, 32'h0, 1'b0},
        '{OP_TICK,  REG_MODE,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{OP_TICK,  REG_ALARM,  32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{OP_READ,  REG_VALUE,  32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{OP_READ,  REG_STATUS, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{OP_WRITE, REG_ALARM,  32'h0000_0003, 1'b0, 32'h0, 1'b0},
        '{OP_TICK,  REG_VALUE,  32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{OP_READ,  REG_STATUS, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{OP_WRITE, REG_VALUE,  32'hffff_ffff, 1'b0, 32'h0, 1'b0},
        '{OP_WRITE, REG_STATUS, 32'hffff_ffff, 1'b0, 32'h0, 1'b0},
        '{OP_READ,  REG_VALUE,  32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{OP_WRITE, REG_MODE,   32'hfff8_0000, 1'b0, 32'h0, 1'b0},
        '{OP_READ,  REG_MODE,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{OP_TICK,  REG_STATUS, 32'hffff_ffff, 1'b0, 32'h0, 1'b0},
        '{OP_WRITE, REG_MODE,   32'h0000_ffff, 1'b0, 32'h0, 1'b0},
        '{OP_TICK,  REG_MODE,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{OP_READ,  REG_MODE,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{OP_WRITE, REG_ALARM,  32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{OP_WRITE, REG_MODE,   32'h0004_0002, 1'b0, 32'h0, 1'b0},
        '{OP_READ,  REG_STATUS, 32'h0000_0000, 1'b0, 32'h0, 1'b0}
    };

    // timer state as the block should hold it
    logic [15:0] tmr_prescale = PRESCALE_RESET;
    logic        tmr_alm_en = 1'b0;
    logic        tmr_inc_en = 1'b0;
    logic [15:0] tmr_pcount = '0;
    logic [31:0] tmr_count = '0;
    logic [31:0] tmr_alarm = '1;
    logic        flag_alarm = 1'b0;
    logic        flag_incr = 1'b0;

    t_result timer_results_q [$];
    t_result got_res;
    t_result exp_res;
    int      mismatch_count = 0;
    int      stall_cycles = 0;
    bit      steady_flow = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit take_gap();
        return !steady_flow && ($urandom_range(0, 99) < 26);
    endfunction

    task automatic timer_step(input logic [1:0] op, input logic [1:0] idx,
                              input logic [31:0] data, output t_result res);
        logic [16:0] period;
        logic [16:0] nxt;
        logic [31:0] rd;
        rd = '0;
        case (op)
            OP_TICK: begin
                // zero prescaler counts the full 2^16 period
                period = (tmr_prescale == '0) ? 17'h1_0000 : {1'b0, tmr_prescale};
                nxt = {1'b0, tmr_pcount} + 17'd1;
                if (nxt >= period) begin
                    tmr_pcount = '0;
                    tmr_count = tmr_count + 32'd1;
                    flag_incr = 1'b1;
                    if (tmr_count == tmr_alarm)
                        flag_alarm = 1'b1;
                end else begin
                    tmr_pcount = nxt[15:0];
                end
            end
            OP_READ: begin
                case (idx)
                    REG_MODE: begin
                        rd[15:0] = tmr_prescale;
                        rd[MODE_ALM_EN] = tmr_alm_en;
                        rd[MODE_INC_EN] = tmr_inc_en;
                    end
                    REG_ALARM: rd = tmr_alarm;
                    REG_VALUE: rd = tmr_count;
                    default: begin
                        rd[STAT_ALARM] = flag_alarm;
                        rd[STAT_INCR] = flag_incr;
                        flag_alarm = 1'b0;
                        flag_incr = 1'b0;
                    end
                endcase
            end
            OP_WRITE: begin
                if (idx == REG_MODE) begin
                    tmr_prescale = data[15:0];
                    tmr_alm_en = data[MODE_ALM_EN];
                    tmr_inc_en = data[MODE_INC_EN];
                    // counter reset leaves the flags alone and skips the alarm compare
                    if (data[MODE_RST]) begin
                        tmr_pcount = '0;
                        tmr_count = '0;
                    end
                end else if (idx == REG_ALARM) begin
                    tmr_alarm = data;
                end
            end
            default: ;
        endcase
        res.read_data = rd;
        res.irq = (flag_alarm & tmr_alm_en) | (flag_incr & tmr_inc_en);
    endtask

    // returns in the time step of the edge that accepts the request
    task automatic send_request(input logic [1:0] op, input logic [1:0] idx,
                                input logic [31:0] data);
        while (take_gap()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_reg_index <= idx;
        i_write_data <= data;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic issue(input logic [1:0] op, input logic [1:0] idx, input logic [31:0] data);
        t_result res;
        send_request(op, idx, data);
        timer_step(op, idx, data, res);
        timer_results_q.push_back(res);
    endtask

    // result side: checking, ready stalls and the watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_cycles <= 0;
        end else begin
            if (o_valid && i_ready) begin
                got_res.read_data = o_read_data;
                got_res.irq = o_irq;
                if (timer_results_q.size() == 0) begin
                    $error("unexpected result read_data=%h irq=%b", o_read_data, o_irq);
                    mismatch_count++;
                end else begin
                    exp_res = timer_results_q.pop_front();
                    if (got_res.read_data !== exp_res.read_data) begin
                        $error("read_data expected %h actual %h",
                               exp_res.read_data, got_res.read_data);
                        mismatch_count++;
                    end
                    if (got_res.irq !== exp_res.irq) begin
                        $error("irq expected %b actual %b", exp_res.irq, got_res.irq);
                        mismatch_count++;
                    end
                end
            end
            if ((o_valid && i_ready) || (i_valid && o_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("real_time_timer_with_alarm_unit_test failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            i_ready <= steady_flow || ($urandom_range(0, 99) >= 26);
        end
    end

    initial begin
        t_result res;
        logic [1:0]  op;
        logic [1:0]  idx;
        logic [31:0] data;
        int          pick;
        int          wsel;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < DIR_N; n++) begin
            send_request(dir_rows[n].op, dir_rows[n].idx, dir_rows[n].data);
            timer_step(dir_rows[n].op, dir_rows[n].idx, dir_rows[n].data, res);
            if (dir_rows[n].known) begin
                res.read_data = dir_rows[n].rd;
                res.irq = dir_rows[n].irq;
            end
            timer_results_q.push_back(res);
        end

        // a zero prescaler holds the count through a short burst of ticks
        issue(OP_WRITE, REG_ALARM, 32'h0000_0001);
        issue(OP_WRITE, REG_MODE, 32'h0007_0000);
        issue(OP_READ, REG_STATUS, '0);
        for (int n = 0; n < 16; n++)
            issue(OP_TICK, 2'($urandom_range(0, 3)), $urandom());
        issue(OP_READ, REG_STATUS, '0);
        issue(OP_READ, REG_VALUE, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady_flow = (n >= 200 && n < 300);
            if (n == 400) begin
                // hold off until the pipe is empty
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (timer_results_q.size() != 0) @(posedge i_clk);
            end
            pick = $urandom_range(0, 99);
            idx = 2'($urandom_range(0, 3));
            data = $urandom();
            if (pick < 50) begin
                op = OP_TICK;
            end else if (pick < 72) begin
                op = OP_READ;
            end else if (pick < 97) begin
                op = OP_WRITE;
                wsel = $urandom_range(0, 9);
                if (wsel < 4) begin
                    idx = REG_MODE;
                    if (wsel != 0) begin
                        data[15:0] = 16'($urandom_range(1, 4));
                        data[MODE_RST] = ($urandom_range(0, 4) == 0);
                    end
                end else if (wsel < 8) begin
                    idx = REG_ALARM;
                    if (wsel != 7)
                        data = tmr_count + 32'($urandom_range(0, 4));
                end
            end else begin
                op = OP_NONE;
            end
            issue(op, idx, data);
        end
        steady_flow = 1'b0;
        i_valid <= 1'b0;

        while (timer_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && timer_results_q.size() == 0) begin
            $display("real_time_timer_with_alarm_unit_test passed");
        end else begin
            $display("real_time_timer_with_alarm_unit_test failed");
        end
        $finish;
    end

endmodule
